// ===== hdl/tga_rle_pkg.sv =====
// Shared constants for the Targa run-length pixel decoder.
package tga_rle_pkg;

   // Field widths.
   localparam int DIM_W      = 9;
   localparam int HDR_W      = 16;
   localparam int BITS_W     = 8;
   localparam int BYTE_W     = 8;
   localparam int COLOR_W    = 32;
   localparam int ADDR_W     = 16;
   localparam int COUNT_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_DIM_DEFAULT = 256;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_BITS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RLE_MODE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_ORDER = 3'd6;

   // Register reset values.
   localparam logic [DIM_W-1:0]  RST_TARGET_WIDTH  = 9'd16;
   localparam logic [DIM_W-1:0]  RST_TARGET_HEIGHT = 9'd11;
   localparam logic [HDR_W-1:0]  RST_HEADER_WIDTH  = 16'd16;
   localparam logic [HDR_W-1:0]  RST_HEADER_HEIGHT = 16'd11;
   localparam logic [BITS_W-1:0] RST_PIXEL_BITS    = 8'd24;

   localparam logic [BITS_W-1:0] BITS_24 = 8'd24;
   localparam logic [BITS_W-1:0] BITS_32 = 8'd32;
   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hff;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLIPPED = 2'd2;

endpackage

// ===== hdl/tga_rle_if.sv =====
// Handshake channel interfaces for the decoder: data bytes, pixel results, register writes.
interface tga_rle_req_if;
   logic                               valid;
   logic                               ready;
   logic [tga_rle_pkg::BYTE_W-1:0]     data_byte;
   logic                               start_of_image;
   modport source (output valid, output data_byte, output start_of_image, input ready);
   modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

interface tga_rle_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tga_rle_pkg::COLOR_W-1:0]    pixel_color;
   logic [tga_rle_pkg::ADDR_W-1:0]     pixel_address;
   logic [tga_rle_pkg::COUNT_W-1:0]    run_count;
   logic                               last_pixel;
   logic [tga_rle_pkg::STATUS_W-1:0]   status;
   modport source (output valid, output pixel_color, output pixel_address,
                   output run_count, output last_pixel, output status, input ready);
   modport sink   (input valid, input pixel_color, input pixel_address,
                   input run_count, input last_pixel, input status, output ready);
endinterface

interface tga_rle_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [tga_rle_pkg::CSR_IDX_W-1:0]    index;
   logic [tga_rle_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/tga_rle_pixel_decoder_top.sv =====
// Targa pixel-data decoder: one data byte per transfer, one ARGB pixel or run per result.
// Results are registered. Throughput: one byte per cycle while the skid entry is empty; the
// stream state updates in a single pass between the state registers and a two-entry result
// buffer, so a byte is taken while one result waits.
// Reset (synchronous) restores the register defaults and clears packet, pixel, row and column state.
module tga_rle_pixel_decoder_top #(
   parameter int MAX_DIM = tga_rle_pkg::MAX_DIM_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   tga_rle_req_if.sink      req,
   tga_rle_rsp_if.source    rsp,
   tga_rle_csr_if.sink      csr
);

   localparam int DW = tga_rle_pkg::DIM_W;

   typedef struct packed {
      logic [tga_rle_pkg::COLOR_W-1:0]  pixel_color;
      logic [tga_rle_pkg::ADDR_W-1:0]   pixel_address;
      logic [tga_rle_pkg::COUNT_W-1:0]  run_count;
      logic                             last_pixel;
      logic [tga_rle_pkg::STATUS_W-1:0] status;
   } result_type;

   // Configuration registers.
   logic [DW-1:0]                    target_width_ff, target_height_ff;
   logic [tga_rle_pkg::HDR_W-1:0]    header_width_ff, header_height_ff;
   logic [tga_rle_pkg::BITS_W-1:0]   pixel_bits_ff;
   logic                             rle_mode_ff, rows_in_order_ff;

   // Stream state.
   logic          expect_ff, expect_in;
   logic          is_run_ff, is_run_in;
   logic [7:0]    left_ff, left_in;
   logic [1:0]    bip_ff, bip_in;
   logic [23:0]   color_ff, color_in;
   logic [DW-1:0] column_ff, column_in;
   logic [DW-1:0] row_ff, row_in;
   logic          done_ff, done_in;

   // Result buffer.
   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff;

   logic       accept, sop, pop, has_result;
   result_type result;

   // Effective state after an optional start-of-image clear.
   logic          exp_cur, run_cur, done_cur;
   logic [7:0]    left_cur;
   logic [1:0]    bip_cur, last_idx;
   logic [23:0]   color_cur;
   logic [DW-1:0] column_cur, row_cur;

   logic                  reject;
   logic [7:0]            count_cur;
   logic signed [DW:0]    base_s;
   logic signed [2*DW+1:0] prod_s;
   logic signed [2*DW+2:0] addr_s;
   logic                  addr_neg;
   logic [2*DW+1:0]       addr_mag;
   logic [2*DW-1:0]       total;
   logic [2*DW+2:0]       end_sum;
   logic [DW:0]           col_sum;
   logic [DW-1:0]         row_inc;
   logic [7:0]            clip_count;

   assign accept  = req.valid && req.ready;
   assign sop     = req.start_of_image;
   assign pop     = out_valid_ff && rsp.ready;
   assign req.ready = !skid_valid_ff;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_width_ff  <= tga_rle_pkg::RST_TARGET_WIDTH;
         target_height_ff <= tga_rle_pkg::RST_TARGET_HEIGHT;
         header_width_ff  <= tga_rle_pkg::RST_HEADER_WIDTH;
         header_height_ff <= tga_rle_pkg::RST_HEADER_HEIGHT;
         pixel_bits_ff    <= tga_rle_pkg::RST_PIXEL_BITS;
         rle_mode_ff      <= 1'b0;
         rows_in_order_ff <= 1'b0;
      end else if (csr.valid) begin
         unique case (csr.index)
            tga_rle_pkg::CSR_TARGET_WIDTH:  target_width_ff  <= csr.data[DW-1:0];
            tga_rle_pkg::CSR_TARGET_HEIGHT: target_height_ff <= csr.data[DW-1:0];
            tga_rle_pkg::CSR_HEADER_WIDTH:  header_width_ff  <= csr.data;
            tga_rle_pkg::CSR_HEADER_HEIGHT: header_height_ff <= csr.data;
            tga_rle_pkg::CSR_PIXEL_BITS:    pixel_bits_ff    <= csr.data[7:0];
            tga_rle_pkg::CSR_RLE_MODE:      rle_mode_ff      <= csr.data[0];
            tga_rle_pkg::CSR_ROWS_IN_ORDER: rows_in_order_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   assign exp_cur    = sop ? 1'b1 : expect_ff;
   assign run_cur    = sop ? 1'b0 : is_run_ff;
   assign left_cur   = sop ? 8'd0 : left_ff;
   assign bip_cur    = sop ? 2'd0 : bip_ff;
   assign color_cur  = sop ? 24'd0 : color_ff;
   assign column_cur = sop ? '0 : column_ff;
   assign row_cur    = sop ? '0 : row_ff;
   assign done_cur   = sop ? 1'b0 : done_ff;

   assign reject = (pixel_bits_ff != tga_rle_pkg::BITS_24 &&
                    pixel_bits_ff != tga_rle_pkg::BITS_32) ||
                   header_width_ff != {{(tga_rle_pkg::HDR_W-DW){1'b0}}, target_width_ff} ||
                   header_height_ff != {{(tga_rle_pkg::HDR_W-DW){1'b0}}, target_height_ff} ||
                   target_width_ff == '0 || target_width_ff > DW'(MAX_DIM) ||
                   target_height_ff == '0 || target_height_ff > DW'(MAX_DIM);

   assign last_idx  = (pixel_bits_ff == tga_rle_pkg::BITS_32) ? 2'd3 : 2'd2;
   assign count_cur = (rle_mode_ff && run_cur) ? left_cur : 8'd1;

   // The flipped row base goes negative when the height shrank to or below the current row;
   // such an address lies beyond the buffer, unless the column pulls it back.
   assign base_s = rows_in_order_ff ? $signed({1'b0, row_cur})
                 : $signed({1'b0, target_height_ff}) - $signed({1'b0, row_cur})
                   - $signed((DW+1)'(1));
   assign prod_s   = base_s * $signed({1'b0, target_width_ff});
   assign addr_s   = (2*DW+3)'(prod_s) + $signed({{(DW+3){1'b0}}, column_cur});
   assign addr_neg = addr_s[2*DW+2];
   assign addr_mag = addr_s[2*DW+1:0];
   assign total    = target_width_ff * target_height_ff;
   assign end_sum  = {1'b0, addr_mag} + {{(2*DW-5){1'b0}}, count_cur};
   assign clip_count = 8'((2*DW+2)'(total) - addr_mag);

   assign col_sum = {1'b0, column_cur} + {{(DW-7){1'b0}}, count_cur};
   assign row_inc = row_cur + DW'(1);

   always_comb begin
      expect_in  = exp_cur;
      is_run_in  = run_cur;
      left_in    = left_cur;
      bip_in     = bip_cur;
      color_in   = color_cur;
      column_in  = column_cur;
      row_in     = row_cur;
      done_in    = done_cur;
      has_result = 1'b0;
      result     = '0;
      if (reject) begin
         has_result    = 1'b1;
         result.status = tga_rle_pkg::STATUS_REJECT;
      end else if (!done_cur) begin
         if (rle_mode_ff && exp_cur) begin
            is_run_in = req.data_byte[7];
            left_in   = {1'b0, req.data_byte[6:0]} + 8'd1;
            expect_in = 1'b0;
            bip_in    = 2'd0;
         end else begin
            unique case (bip_cur)
               2'd0:    color_in[7:0]   = req.data_byte;
               2'd1:    color_in[15:8]  = req.data_byte;
               2'd2:    color_in[23:16] = req.data_byte;
               default: ;
            endcase
            if (bip_cur < last_idx) begin
               bip_in = bip_cur + 2'd1;
            end else begin
               bip_in     = 2'd0;
               has_result = 1'b1;
               result.pixel_color = {(last_idx == 2'd3) ? req.data_byte
                                     : tga_rle_pkg::ALPHA_OPAQUE, color_in};
               column_in = col_sum[DW-1:0];
               // A raw packet in run-length mode only ends on its last pixel.
               if (rle_mode_ff && !run_cur && left_cur > 8'd1) begin
                  left_in = left_cur - 8'd1;
               end else begin
                  if (rle_mode_ff) begin
                     left_in   = 8'd0;
                     expect_in = 1'b1;
                  end
                  if (col_sum >= {1'b0, target_width_ff}) begin
                     column_in = '0;
                     row_in    = row_inc;
                     if (row_inc >= target_height_ff) begin
                        done_in           = 1'b1;
                        result.last_pixel = 1'b1;
                     end
                  end
               end
               if (addr_neg || addr_mag >= (2*DW+2)'(total)) begin
                  result.run_count = 8'd0;
                  result.status    = tga_rle_pkg::STATUS_CLIPPED;
               end else if (end_sum > (2*DW+3)'(total)) begin
                  result.run_count = clip_count;
                  result.status    = tga_rle_pkg::STATUS_CLIPPED;
               end else begin
                  result.run_count = count_cur;
                  result.status    = tga_rle_pkg::STATUS_OK;
               end
               if (addr_neg || addr_mag > (2*DW+2)'(16'hffff)) begin
                  result.pixel_address = 16'hffff;
               end else begin
                  result.pixel_address = addr_mag[15:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= 1'b1;
         is_run_ff <= 1'b0;
         left_ff   <= 8'd0;
         bip_ff    <= 2'd0;
         color_ff  <= 24'd0;
         column_ff <= '0;
         row_ff    <= '0;
         done_ff   <= 1'b0;
      end else if (accept) begin
         expect_ff <= expect_in;
         is_run_ff <= is_run_in;
         left_ff   <= left_in;
         bip_ff    <= bip_in;
         color_ff  <= color_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         done_ff   <= done_in;
      end
   end

   // Two-entry result buffer: the skid entry catches a result while the output is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_valid_ff && !pop) begin
         if (accept && has_result) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end else begin
         out_valid_ff <= accept && has_result;
         if (accept && has_result) begin
            out_ff <= result;
         end
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pixel_color   = out_ff.pixel_color;
   assign rsp.pixel_address = out_ff.pixel_address;
   assign rsp.run_count     = out_ff.run_count;
   assign rsp.last_pixel    = out_ff.last_pixel;
   assign rsp.status        = out_ff.status;

endmodule
